[rtl/itf_pkg.sv]
// Shared types, codes and helper functions for the integer text formatter.
`timescale 1ns / 1ps
package itf_pkg;

	// Largest number of characters in one formatted field.
	localparam int MAX_CHARS = 64;

	// Radix codes.
	localparam logic [1:0] RADIX_DEC = 2'd0;
	localparam logic [1:0] RADIX_HEX = 2'd1;
	localparam logic [1:0] RADIX_OCT = 2'd2;
	localparam logic [1:0] RADIX_BIN = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_RADIX = 3'd0;
	localparam logic [2:0] REG_WIDTH = 3'd1;
	localparam logic [2:0] REG_PAD   = 3'd2;
	localparam logic [2:0] REG_LEFT  = 3'd3;
	localparam logic [2:0] REG_FULL  = 3'd4;
	localparam logic [2:0] REG_ZPAD  = 3'd5;

	// Type width codes.
	localparam logic [1:0] TW_8  = 2'd0;
	localparam logic [1:0] TW_16 = 2'd1;
	localparam logic [1:0] TW_32 = 2'd2;
	localparam logic [1:0] TW_64 = 2'd3;

	// Output phases of one field.
	localparam logic [1:0] PH_PRE  = 2'd0;
	localparam logic [1:0] PH_PFX  = 2'd1;
	localparam logic [1:0] PH_DIG  = 2'd2;
	localparam logic [1:0] PH_POST = 2'd3;

	// ASCII characters.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_B     = 8'h62;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       conv;
		logic       meas;
		logic       plan;
		logic       emit;
		logic [1:0] phase;
		logic [6:0] cnt;
		logic       last;
	} cmd_t;

	// Status from the datapath: mode and the length of each phase.
	typedef struct packed {
		logic       is_dec;
		logic [6:0] pre_n;
		logic [6:0] pfx_n;
		logic [6:0] dig_n;
		logic [6:0] post_n;
	} stat_t;

	// Upper-case hex digit.
	function automatic logic [7:0] hex_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + {4'd0, d};
		end
		return 8'h37 + {4'd0, d};
	endfunction

	// Digits needed to show the whole type width in a power-of-two radix.
	function automatic logic [6:0] zero_digits(input logic [1:0] radix, input logic [1:0] tw);
		logic [6:0] r;
		r = 7'd1;
		unique case (radix)
			RADIX_HEX: begin
				unique case (tw)
					TW_8:    r = 7'd2;
					TW_16:   r = 7'd4;
					TW_32:   r = 7'd8;
					default: r = 7'd16;
				endcase
			end
			RADIX_OCT: begin
				unique case (tw)
					TW_8:    r = 7'd3;
					TW_16:   r = 7'd6;
					TW_32:   r = 7'd11;
					default: r = 7'd22;
				endcase
			end
			RADIX_BIN: begin
				unique case (tw)
					TW_8:    r = 7'd8;
					TW_16:   r = 7'd16;
					TW_32:   r = 7'd32;
					default: r = 7'd64;
				endcase
			end
			default: r = 7'd1;
		endcase
		return r;
	endfunction

endpackage

[rtl/itf_ctrl.sv]
// Controller state machine: sequences conversion, sizing and character output.
`timescale 1ns / 1ps
module itf_ctrl import itf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_MEAS = 3'd2;
	localparam logic [2:0] ST_PLAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q, state_d;
	logic [5:0] bit_q;
	logic [1:0] phase_q;
	logic [6:0] cnt_q;
	logic       valid_q;
	logic [6:0] plen [4];
	logic [1:0] eff;
	logic       later_nz;
	logic       cur_done;
	logic       out_free;
	logic       accept;

	assign plen[0] = stat.pre_n;
	assign plen[1] = stat.pfx_n;
	assign plen[2] = stat.dig_n;
	assign plen[3] = stat.post_n;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = valid_q;
	assign out_free  = !valid_q || out_ready;

	// Skip phases that are empty and look for characters after this one.
	always_comb begin
		eff = PH_POST;
		for (int i = 3; i >= 0; i--) begin
			if (2'(i) >= phase_q && plen[i] != 7'd0) begin
				eff = 2'(i);
			end
		end
		later_nz = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (2'(i) > eff && plen[i] != 7'd0) begin
				later_nz = 1'b1;
			end
		end
		cur_done = (cnt_q + 7'd1 >= plen[eff]);
	end

	// Commands.
	always_comb begin
		cmd       = '0;
		cmd.load  = accept;
		cmd.conv  = (state_q == ST_CONV);
		cmd.meas  = (state_q == ST_MEAS);
		cmd.plan  = (state_q == ST_PLAN);
		cmd.emit  = (state_q == ST_EMIT) && out_free;
		cmd.phase = eff;
		cmd.cnt   = cnt_q;
		cmd.last  = cur_done && !later_nz;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = stat.is_dec ? ST_CONV : ST_MEAS;
				end
			end
			ST_CONV: begin
				if (bit_q == 6'd63) begin
					state_d = ST_MEAS;
				end
			end
			ST_MEAS: state_d = ST_PLAN;
			ST_PLAN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (cmd.emit && cmd.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			phase_q <= PH_PRE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CONV) begin
				bit_q <= bit_q + 6'd1;
			end else begin
				bit_q <= '0;
			end
			if (state_q == ST_PLAN) begin
				phase_q <= PH_PRE;
				cnt_q   <= '0;
			end else if (cmd.emit) begin
				if (cur_done) begin
					phase_q <= (eff == PH_POST) ? PH_POST : eff + 2'd1;
					cnt_q   <= '0;
				end else begin
					phase_q <= eff;
					cnt_q   <= cnt_q + 7'd1;
				end
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/itf_dp.sv]
// Datapath: configuration registers, binary to BCD converter, sizing and character select.
`timescale 1ns / 1ps
module itf_dp import itf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [6:0]  wr_data,
	input  logic [63:0] value,
	input  logic        is_signed,
	input  logic [1:0]  type_width,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic [7:0]  text_char,
	output logic        last_char
);

	logic [1:0]  radix_q;
	logic [6:0]  width_q;
	logic        pad_q, left_q, full_q, zpad_q;

	logic [63:0] v_q, mag_q;
	logic [79:0] bcd_q;
	logic        neg_q;
	logic [1:0]  tw_q;
	logic [6:0]  nd_q;
	logic        fits_q;
	stat_t       stat_q;
	logic [7:0]  char_q;
	logic        last_q;

	logic [63:0] mask, v_m, mag_in;
	logic        neg_in;
	logic [79:0] bcd_adj;
	logic [6:0]  nd_dec, nd_bin;
	logic [5:0]  msb;
	logic [6:0]  ndec3;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_DEC;
			width_q <= '0;
			pad_q   <= 1'b0;
			left_q  <= 1'b0;
			full_q  <= 1'b0;
			zpad_q  <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RADIX: radix_q <= wr_data[1:0];
				REG_WIDTH: width_q <= wr_data;
				REG_PAD:   pad_q   <= wr_data[0];
				REG_LEFT:  left_q  <= wr_data[0];
				REG_FULL:  full_q  <= wr_data[0];
				REG_ZPAD:  zpad_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Mask to the type width, find the sign and the magnitude.
	always_comb begin
		unique case (type_width)
			TW_8:    mask = 64'h0000_0000_0000_00FF;
			TW_16:   mask = 64'h0000_0000_0000_FFFF;
			TW_32:   mask = 64'h0000_0000_FFFF_FFFF;
			default: mask = '1;
		endcase
		v_m = value & mask;
		unique case (type_width)
			TW_8:    neg_in = is_signed && v_m[7];
			TW_16:   neg_in = is_signed && v_m[15];
			TW_32:   neg_in = is_signed && v_m[31];
			default: neg_in = is_signed && v_m[63];
		endcase
		mag_in = neg_in ? ((~v_m + 64'd1) & mask) : v_m;
	end

	// Double-dabble correction of every BCD digit.
	always_comb begin
		for (int i = 0; i < 20; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
				: bcd_q[i*4 +: 4];
		end
	end

	// Number of significant digits.
	always_comb begin
		nd_dec = 7'd1;
		for (int i = 0; i < 20; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) begin
				nd_dec = 7'(i + 1);
			end
		end
		msb = '0;
		for (int i = 0; i < 64; i++) begin
			if (v_q[i]) begin
				msb = 6'(i);
			end
		end
		ndec3 = 7'(({7'd0, msb} * 13'd43) >> 7);
		unique case (radix_q)
			RADIX_HEX: nd_bin = {3'd0, msb[5:2]} + 7'd1;
			RADIX_OCT: nd_bin = ndec3 + 7'd1;
			default:   nd_bin = {1'b0, msb} + 7'd1;
		endcase
	end

	// Input capture, conversion steps and digit count.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q   <= v_m;
			mag_q <= mag_in;
			neg_q <= neg_in;
			tw_q  <= type_width;
			bcd_q <= '0;
		end else if (cmd.conv) begin
			bcd_q <= {bcd_adj[78:0], mag_q[63]};
			mag_q <= {mag_q[62:0], 1'b0};
		end
		if (cmd.meas) begin
			nd_q <= (radix_q == RADIX_DEC) ? nd_dec : nd_bin;
		end
	end

	// Field sizing.
	logic [7:0] w, hdr, zp, nd_f, len, npad;
	logic       padon, fits;
	always_comb begin
		if (width_q == 7'd0 || width_q > 7'(MAX_CHARS)) begin
			w = 8'(MAX_CHARS);
		end else begin
			w = {1'b0, width_q};
		end
		padon = pad_q && (width_q != 7'd0);
		zp    = {1'b0, zero_digits(radix_q, tw_q)};
		nd_f  = {1'b0, nd_q};
		if (radix_q == RADIX_DEC) begin
			hdr = {7'd0, neg_q || full_q};
		end else begin
			hdr = full_q ? 8'd2 : 8'd0;
		end
		fits = (hdr + nd_f <= w);
		if (radix_q != RADIX_DEC && zpad_q && zp > nd_f) begin
			nd_f = (hdr + zp > w) ? w - hdr : zp;
		end
		if (!fits) begin
			hdr  = 8'd1;
			nd_f = 8'd0;
		end
		len  = hdr + nd_f;
		npad = (padon && w > len) ? w - len : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '0;
			fits_q <= 1'b1;
		end else if (cmd.plan) begin
			stat_q.pfx_n  <= hdr[6:0];
			stat_q.dig_n  <= nd_f[6:0];
			stat_q.pre_n  <= left_q ? 7'd0 : npad[6:0];
			stat_q.post_n <= left_q ? npad[6:0] : 7'd0;
			fits_q        <= fits;
		end
	end

	assign stat.is_dec = (radix_q == RADIX_DEC);
	assign stat.pre_n  = stat_q.pre_n;
	assign stat.pfx_n  = stat_q.pfx_n;
	assign stat.dig_n  = stat_q.dig_n;
	assign stat.post_n = stat_q.post_n;

	// Character select.
	logic [6:0]  idx;
	logic [7:0]  sh;
	logic [63:0] shv;
	logic [3:0]  dig;
	logic [7:0]  ch;
	always_comb begin
		idx = stat_q.dig_n - 7'd1 - cmd.cnt;
		unique case (radix_q)
			RADIX_HEX: sh = {idx, 1'b0} << 1;
			RADIX_OCT: sh = {1'b0, idx} + {idx, 1'b0};
			default:   sh = {1'b0, idx};
		endcase
		shv = v_q >> sh[5:0];
		unique case (radix_q)
			RADIX_DEC: dig = bcd_q[idx[4:0]*4 +: 4];
			RADIX_HEX: dig = shv[3:0];
			RADIX_OCT: dig = {1'b0, shv[2:0]};
			default:   dig = {3'b0, shv[0]};
		endcase
		unique case (cmd.phase)
			PH_PFX: begin
				if (!fits_q) begin
					ch = CH_QUEST;
				end else if (radix_q == RADIX_DEC) begin
					ch = neg_q ? CH_MINUS : CH_PLUS;
				end else if (cmd.cnt == 7'd0) begin
					ch = CH_ZERO;
				end else begin
					ch = (radix_q == RADIX_HEX) ? CH_X : ((radix_q == RADIX_OCT) ? CH_O : CH_B);
				end
			end
			PH_DIG:  ch = hex_char(dig);
			default: ch = CH_SPACE;
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= ch;
			last_q <= cmd.last;
		end
	end

	assign text_char = char_q;
	assign last_char = last_q;

endmodule

[rtl/integer_to_text_formatter.sv]
// Top level of the integer to ASCII text formatter.
//
// Channel   Direction  tdata                     tuser / tlast
// s_axis    in         [63:0] value              tuser [0] is_signed, [2:1] type_width
// m_axis    out        [7:0] text_char           tlast last_char
// wr_*      in         register write: index, 7-bit data
//
// A request is loaded, then converted from binary to BCD in decimal mode only
// (conversion is skipped otherwise), then the field is sized in the measure and
// plan steps, then one character is sent per cycle while the output is taken.
// Output stalls hold the sequence; a new request is taken once the last character
// sits in the output register. Reset is asynchronous and clears the control state.
`timescale 1ns / 1ps
module integer_to_text_formatter import itf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [6:0]  wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] value
	input  logic [2:0]  s_axis_tuser,   // [0] is_signed, [2:1] type_width
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] text_char
	output logic        m_axis_tlast
);

	cmd_t  cmd;
	stat_t stat;

	itf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	itf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.value      (s_axis_tdata),
		.is_signed  (s_axis_tuser[0]),
		.type_width (s_axis_tuser[2:1]),
		.cmd        (cmd),
		.stat       (stat),
		.text_char  (m_axis_tdata),
		.last_char  (m_axis_tlast)
	);

endmodule
